>>> rtl/core/pem_pkg.sv
// Package for the Prewitt edge magnitude unit: field widths, register
// indexes and reset values of the configuration registers.
// No dependencies.
package pem_pkg;

  // Default line length, which sets the depth of each line store.
  localparam int PEM_MAX_WIDTH = 1024;

  // Field widths.
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  // Saturation limit of a gradient and of the magnitude.
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Register values after reset.
  localparam logic [CFG_WID_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]     IMAGE_HEIGHT_RST = 12'd480;

endpackage

>>> rtl/core/prewitt_edge_magnitude_unit.sv
// Prewitt edge magnitude unit: streaming 3x3 window filter over a raster
// pixel stream, with two line stores and an output register.
// Depends on pem_pkg.
//
// The unit takes one 8-bit grey pixel per clock in raster order while
// in_tready is high and, for every interior pixel taken, returns one
// result per clock: the sum of the clamped vertical and horizontal Prewitt
// gradients, saturated at 255, together with the row and column of the
// centre pixel. Border pixels give no result, and tlast marks the last
// interior result of a frame. A result appears in the output register in
// the cycle after the pixel that completes its window; the rate of one
// pixel per clock is set by the single read and single write port of each
// line store, whose read for the next column is issued while the current
// pixel is taken. The line stores (two memories of MAX_WIDTH bytes) need
// no clearing pass: their data reaches a result only from the third row of
// a frame onward, after the first two rows have filled them. Writing either
// register restarts the frame at row 0, column 0; a width below 3 acts as
// 3, above MAX_WIDTH as MAX_WIDTH, and a height below 3 acts as 3.
module prewitt_edge_magnitude_unit
  import pem_pkg::*;
#(
  parameter int MAX_WIDTH = PEM_MAX_WIDTH,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int TDATA_W  = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // edge_value, out_row, out_col, zero fill
  output logic                  out_tlast,  // frame_last
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Last column index of a row for a given width setting.
  function automatic logic [COL_W-1:0] width_last(input logic [CFG_WID_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd3) w = 32'd3;
    if (w > 32'(MAX_WIDTH)) w = 32'(MAX_WIDTH);
    return COL_W'(w - 32'd1);
  endfunction

  // Last row index of a frame for a given height setting.
  function automatic logic [ROW_W-1:0] height_last(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] h;
    h = v;
    if (h < ROW_W'(3)) h = ROW_W'(3);
    return h - ROW_W'(1);
  endfunction

  // Clamp a signed difference to 0..255.
  function automatic logic [PIX_W-1:0] clamp_diff(input logic signed [PIX_W+3:0] d);
    logic [PIX_W-1:0] r;
    if (d < 0) r = '0;
    else if (d > $signed({4'd0, PIX_MAX})) r = PIX_MAX;
    else r = d[PIX_W-1:0];
    return r;
  endfunction

  // Configuration and position state.
  logic [COL_W-1:0] width_last_r;
  logic [ROW_W-1:0] height_last_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             cfg_wr;
  logic             in_xfer;

  // Window and line stores.
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_rd_r;
  logic [PIX_W-1:0] mid_rd_r;

  // Datapath signals.
  logic                    emit;
  logic                    frame_end;
  logic [PIX_W+1:0]        top_sum, bot_sum, left_sum, right_sum;
  logic [PIX_W-1:0]        grad_v, grad_h;
  logic [PIX_W:0]          mag_sum;
  logic [PIX_W-1:0]        mag;

  // Result register.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_edge_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;

  // Handshakes: a pixel is taken whenever the result register is free or
  // being emptied in the same cycle and no configuration write is offered.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_tready = (~out_valid_r | out_tready) & ~cfg_valid;
  assign in_xfer   = in_tvalid & in_tready;

  // Next raster position.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_xfer) begin
      if (col_r == width_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == height_last_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Configuration registers, kept as last column and last row indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= width_last(IMAGE_WIDTH_RST);
      height_last_r <= height_last(IMAGE_HEIGHT_RST);
      col_r         <= '0;
      row_r         <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_last_r  <= width_last(cfg_data[CFG_WID_W-1:0]);
          REG_IMAGE_HEIGHT: height_last_r <= height_last(cfg_data);
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: the read for the next pixel's column is issued every
  // cycle, so the read data always matches the column about to be taken.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      upper_mem[col_r]  <= mid_rd_r;
      middle_mem[col_r] <= in_tdata;
    end
    top_rd_r <= upper_mem[col_nxt];
    mid_rd_r <= middle_mem[col_nxt];
  end

  // Window shift: two previous columns of the three rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (in_xfer) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_rd_r;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_rd_r;
      win_r[4] <= win_r[5];
      win_r[5] <= in_tdata;
    end
  end

  // Gradient magnitude for the centre of the current window.
  always_comb begin
    top_sum   = (PIX_W+2)'(win_r[0]) + (PIX_W+2)'(win_r[1]) + (PIX_W+2)'(top_rd_r);
    bot_sum   = (PIX_W+2)'(win_r[4]) + (PIX_W+2)'(win_r[5]) + (PIX_W+2)'(in_tdata);
    left_sum  = (PIX_W+2)'(win_r[0]) + (PIX_W+2)'(win_r[2]) + (PIX_W+2)'(win_r[4]);
    right_sum = (PIX_W+2)'(top_rd_r) + (PIX_W+2)'(mid_rd_r) + (PIX_W+2)'(in_tdata);
    grad_v    = clamp_diff($signed({2'b00, bot_sum}) - $signed({2'b00, top_sum}));
    grad_h    = clamp_diff($signed({2'b00, right_sum}) - $signed({2'b00, left_sum}));
    mag_sum   = (PIX_W+1)'(grad_v) + (PIX_W+1)'(grad_h);
    mag       = mag_sum[PIX_W] ? PIX_MAX : mag_sum[PIX_W-1:0];
    emit      = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    frame_end = (row_r == height_last_r) && (col_r == width_last_r);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_edge_r <= mag;
      out_row_r  <= row_r - ROW_W'(1);
      out_col_r  <= col_r - COL_W'(1);
      out_last_r <= frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({out_col_r, out_row_r, out_edge_r});
  assign out_tlast  = out_last_r;

  // A result never belongs to a border pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r != '0) && (out_col_r != '0))
    else $error("result emitted for a border pixel");

  // The raster position stays inside the configured frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= width_last_r) && (row_r <= height_last_r))
    else $error("raster position outside the frame");

  // A pixel that completes an interior window loads the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && emit) |=> out_valid_r)
    else $error("interior pixel gave no result");

  // A pixel that completes no window leaves the result register empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !emit) |=> !out_valid_r)
    else $error("result emitted for a border pixel transfer");

endmodule

>>> tb/tb.sv
// Self-checking testbench for prewitt_edge_magnitude_unit: streams grey pixel frames
// through the unit and compares every result against a line-buffer predictor.
// Depends on pem_pkg and the unit itself.
module tb;
  import pem_pkg::*;

  localparam int COL_W         = $clog2(PEM_MAX_WIDTH);
  localparam int TDATA_W       = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int SETTLE_CYCLES = 4;
  localparam int BIG_FRAME_PIX = 64;

  // Indexes outside the register map; a write to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_last;
  } edge_result_t;

  // Tracks the frame position, both line stores and the window, and keeps
  // the magnitudes still owed by the unit in arrival order.
  class magnitude_tracker;
    logic [CFG_WID_W-1:0]  width_reg;
    logic [ROW_W-1:0]      height_reg;
    logic [PIX_W-1:0]      upper_line[];
    logic [PIX_W-1:0]      middle_line[];
    logic [5:0][PIX_W-1:0] window;
    int unsigned           row_cnt;
    int unsigned           col_cnt;
    edge_result_t          pending[$];
    int                    mismatches;

    function new();
      width_reg   = IMAGE_WIDTH_RST;
      height_reg  = IMAGE_HEIGHT_RST;
      upper_line  = new[PEM_MAX_WIDTH];
      middle_line = new[PEM_MAX_WIDTH];
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      window     = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      mismatches = 0;
    endfunction

    // Widths below 3 act as 3 and widths above the store depth as the depth.
    function int unsigned active_width();
      if (width_reg < 3) return 3;
      if (width_reg > PEM_MAX_WIDTH) return PEM_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      if (height_reg < 3) return 3;
      return height_reg;
    endfunction

    // A write to a known register restarts the frame; others are ignored.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data[CFG_WID_W-1:0];
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = data;
      end else begin
        return;
      end
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    function int unsigned clamp_gradient(int d);
      if (d < 0) return 0;
      if (d > 255) return 255;
      return d;
    endfunction

    // One accepted pixel: form the magnitude of the centre of the window it
    // completes, then shift the window and update both line stores.
    function void take_pixel(logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      g;
      int               top_sum;
      int               bot_sum;
      int               left_sum;
      int               right_sum;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      edge_result_t     r;
      w   = active_width();
      h   = active_height();
      c   = col_cnt % PEM_MAX_WIDTH;
      top = upper_line[c];
      mid = middle_line[c];
      if (row_cnt >= 2 && c >= 2) begin
        top_sum   = int'(window[0]) + int'(window[1]) + int'(top);
        bot_sum   = int'(window[4]) + int'(window[5]) + int'(px);
        left_sum  = int'(window[0]) + int'(window[2]) + int'(window[4]);
        right_sum = int'(top) + int'(mid) + int'(px);
        g = clamp_gradient(bot_sum - top_sum) + clamp_gradient(right_sum - left_sum);
        if (g > 255) g = 255;
        r.magnitude  = g[PIX_W-1:0];
        r.row        = ROW_W'(row_cnt - 1);
        r.col        = COL_W'(c - 1);
        r.frame_last = (row_cnt == h - 1) && (c == w - 1);
        pending.push_back(r);
      end
      window[0] = window[1];
      window[1] = top;
      window[2] = window[3];
      window[3] = mid;
      window[4] = window[5];
      window[5] = px;
      upper_line[c]  = mid;
      middle_line[c] = px;
      c++;
      if (c >= w) begin
        c = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
      col_cnt = c;
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest magnitude owed.
    task match_result(logic [PIX_W-1:0] mag, logic [ROW_W-1:0] row,
                      logic [COL_W-1:0] col, logic last);
      edge_result_t want;
      if (pending.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: value %0d row %0d col %0d last %0b",
                                mag, row, col, last));
        return;
      end
      want = pending.pop_front();
      if (mag !== want.magnitude)
        flag_mismatch($sformatf("row %0d col %0d: value %0d, wanted %0d",
                                want.row, want.col, mag, want.magnitude));
      if (row !== want.row)
        flag_mismatch($sformatf("row field %0d, wanted %0d", row, want.row));
      if (col !== want.col)
        flag_mismatch($sformatf("col field %0d, wanted %0d", col, want.col));
      if (last !== want.frame_last)
        flag_mismatch($sformatf("row %0d col %0d: last flag %0b, wanted %0b",
                                want.row, want.col, last, want.frame_last));
    endtask

    task check_drained();
      if (pending.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    random_sent   = 0;
  int unsigned           cycles        = 0;
  logic [PIX_W-1:0]      last_px       = '0;
  magnitude_tracker      tracker;

  prewitt_edge_magnitude_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every result transfer is checked against the oldest owed magnitude.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.match_result(out_tdata[PIX_W-1:0], out_tdata[PIX_W+ROW_W-1:PIX_W],
                           out_tdata[PIX_W+ROW_W+COL_W-1:PIX_W+ROW_W], out_tlast);
  end

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // One pixel transfer, with random idle cycles ahead of it.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_pixel(px);
  endtask

  // Hold the sender until every owed result has come, then let the unit settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of noise, black and white, and smooth gradients.
  function automatic logic [PIX_W-1:0] next_pixel(input logic [PIX_W-1:0] prev);
    int v;
    case ($urandom_range(0, 3))
      0, 1: return PIX_W'($urandom_range(0, 255));
      2: return $urandom_range(0, 1) ? PIX_MAX : '0;
      default: begin
        v = int'(prev) + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
      end
    endcase
  endfunction

  // Three 3x3 frames with width and height written below their minimum:
  // no gradient above zero, both gradients large so the sum saturates, and
  // a plain ramp that stays below the limit.
  task automatic directed_frames();
    logic [PIX_W-1:0] seq[$];
    seq = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,  8'd0,  8'd0,
            8'd0,   8'd0,   8'd60,  8'd0,   8'd0,   8'd60,  8'd70, 8'd70, 8'd130,
            8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70, 8'd80, 8'd90};
    program_register(REG_IMAGE_WIDTH, 12'h800);
    program_register(REG_IMAGE_HEIGHT, 12'd2);
    foreach (seq[i]) send_pixel(seq[i]);
  endtask

  // Start a frame at the given register values and send only its first
  // pixels; with a long row nothing may come out before the third row.
  task automatic big_frame_start(input logic [CFG_DATA_W-1:0] wdata,
                                 input logic [CFG_DATA_W-1:0] hdata,
                                 input int count);
    wait_drained();
    program_register(REG_IMAGE_WIDTH, wdata);
    program_register(REG_IMAGE_HEIGHT, hdata);
    repeat (count) begin
      last_px = next_pixel(last_px);
      send_pixel(last_px);
    end
  endtask

  // New small frame size, then a frame or more of pixels, often stopping
  // mid-frame so that the next write restarts a frame in progress.
  task automatic random_phase(input bit force_pause);
    int unsigned           w;
    int unsigned           h;
    int unsigned           area;
    int                    count;
    int                    pause_at;
    int                    pick;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    if (random_sent < 350) set_idling(20, 60);
    else if (random_sent < 700) set_idling(60, 20);
    else set_idling(0, 0);
    pick = $urandom_range(0, 99);
    if (pick < 70) w = $urandom_range(3, 12);
    else if (pick < 85) w = $urandom_range(13, 40);
    else w = $urandom_range(0, 2);
    h = ($urandom_range(0, 99) < 80) ? $urandom_range(3, 8) : $urandom_range(0, 2);
    // The top data bit lies outside the width register and must be dropped.
    wdata = CFG_DATA_W'(w);
    wdata[CFG_DATA_W-1] = $urandom_range(0, 1);
    hdata = CFG_DATA_W'(h);
    wait_drained();
    case ($urandom_range(0, 3))
      0: program_register(REG_IMAGE_WIDTH, wdata);
      1: program_register(REG_IMAGE_HEIGHT, hdata);
      2: begin
        program_register(REG_IMAGE_WIDTH, wdata);
        program_register(REG_IMAGE_HEIGHT, hdata);
      end
      default: begin
        program_register(REG_IMAGE_HEIGHT, hdata);
        program_register(REG_IMAGE_WIDTH, wdata);
      end
    endcase
    area  = tracker.active_width() * tracker.active_height();
    count = area * ((area > 100) ? 1 : $urandom_range(1, 3))
            + $urandom_range(0, 2 * tracker.active_width());
    pause_at = (force_pause || $urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        // Drain mid-frame; a write to an unmapped index must not restart it.
        wait_drained();
        if ($urandom_range(0, 1))
          program_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                           CFG_DATA_W'($urandom()));
      end
      last_px = next_pixel(last_px);
      send_pixel(last_px);
      random_sent++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(20, 60);
    directed_frames();
    while (random_sent < 700) random_phase(random_sent == 0);

    // Largest register values (width data above the store depth): a short
    // start of a frame only.
    set_idling(0, 0);
    big_frame_start(12'hFFF, 12'hFFF, BIG_FRAME_PIX);

    while (random_sent < RANDOM_ITEMS) random_phase(1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    tracker.check_drained();
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
